@@ src/linear_search_key_table_unit_defines.svh @@
// Assertion macros for the linear search key table unit.
// Used by the top level; they expect clk and rst_n in scope.
`ifndef LINEAR_SEARCH_KEY_TABLE_UNIT_DEFINES_SVH
`define LINEAR_SEARCH_KEY_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define LSKT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lskt_pkg.sv @@
// Shared types and constants for the linear search key table unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lskt_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W  = 2;
    localparam int KEY_W = 32;
    localparam int POS_W = 10;
    localparam int CMP_W = 11;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_MOVE,
        S_RESULT
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [CMP_W-1:0]   comparisons;
        logic [CMP_W-1:0]   entry_total;
    } res_t;

endpackage

`default_nettype wire

@@ src/lskt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module lskt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ src/lskt_seq.sv @@
// Sequencer for the key table: scan counter, shared key comparator, entry count.
// Depends on lskt_pkg; drives the ports of lskt_ram.
`timescale 1ns / 1ps
`default_nettype none

module lskt_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lskt_pkg::OP_W-1:0]   opcode,
    input  logic [lskt_pkg::KEY_W-1:0]  key,
    output logic                        res_valid,
    input  logic                        res_ready,
    output lskt_pkg::res_t              res,
    output logic                        wr_en,
    output logic [lskt_pkg::IDX_W-1:0]  wr_addr,
    output logic [lskt_pkg::KEY_W-1:0]  wr_data,
    output logic [lskt_pkg::IDX_W-1:0]  rd_addr,
    input  logic [lskt_pkg::KEY_W-1:0]  rd_data
);

    import lskt_pkg::*;

    state_t             state_reg,  state_next;
    logic [OP_W-1:0]    op_reg,     op_next;
    logic [KEY_W-1:0]   key_reg,    key_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   slot_reg,   slot_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    res_t               res_reg,    res_next;

    logic [CNT_W-1:0]   last_idx;
    logic               do_miss;

    assign last_idx  = count_reg - 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        rd_idx_reg <= rd_idx_next;
        slot_reg   <= slot_next;
        res_reg    <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        rd_idx_next = rd_idx_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        res_next    = res_reg;
        rd_addr     = rd_idx_reg + 1'b1;
        wr_en       = 1'b0;
        wr_addr     = count_reg[IDX_W-1:0];
        wr_data     = key_reg;
        do_miss     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    key_next   = key;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (op_reg != OP_INSERT && op_reg != OP_SEARCH && op_reg != OP_REMOVE)
                begin
                    res_next.status      = ST_ABSENT;
                    res_next.position    = '0;
                    res_next.comparisons = '0;
                    res_next.entry_total = CMP_W'(count_reg);
                    state_next           = S_RESULT;
                end
                else if (count_reg == '0)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    rd_addr     = '0;
                    rd_idx_next = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_data == key_reg)
                begin
                    slot_next            = rd_idx_reg;
                    res_next.position    = POS_W'(rd_idx_reg);
                    res_next.comparisons = CMP_W'(CNT_W'(rd_idx_reg) + 1'b1);
                    res_next.entry_total = CMP_W'(count_reg);
                    if (op_reg == OP_INSERT)
                    begin
                        res_next.status = ST_PRESENT;
                        state_next      = S_RESULT;
                    end
                    else if (op_reg == OP_SEARCH)
                    begin
                        res_next.status = ST_OK;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        // fetch the last entry to fill the hole
                        rd_addr    = last_idx[IDX_W-1:0];
                        state_next = S_MOVE;
                    end
                end
                else if (CNT_W'(rd_idx_reg) == last_idx)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_MOVE:
            begin
                wr_en                = 1'b1;
                wr_addr              = slot_reg;
                wr_data              = rd_data;
                count_next           = last_idx;
                res_next.status      = ST_OK;
                res_next.entry_total = CMP_W'(last_idx);
                state_next           = S_RESULT;
            end
            S_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_miss)
        begin
            res_next.comparisons = CMP_W'(count_reg);
            res_next.position    = '0;
            res_next.entry_total = CMP_W'(count_reg);
            res_next.status      = ST_ABSENT;
            if (op_reg == OP_INSERT)
            begin
                if (count_reg == CNT_W'(CAPACITY))
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    wr_en                = 1'b1;
                    wr_addr              = count_reg[IDX_W-1:0];
                    wr_data              = key_reg;
                    count_next           = count_reg + 1'b1;
                    res_next.status      = ST_OK;
                    res_next.position    = POS_W'(count_reg);
                    res_next.entry_total = CMP_W'(count_reg + 1'b1);
                end
            end
            state_next = S_RESULT;
        end
    end

endmodule

`default_nettype wire

@@ src/linear_search_key_table_unit.sv @@
// Steps: accept, a start state, a scan state that compares the stored keys one by one,
// then the result state; a remove hit adds a move state that copies the last entry.
// One item at a time: the scan shares one comparator and one RAM read port.
// Reset clears the entry count and control; the key RAM is not cleared.
// Top level: lskt_seq plus lskt_ram, output register. Depends on lskt_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_search_key_table_unit_defines.svh"

module linear_search_key_table_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lskt_pkg::OP_W-1:0]          opcode,
    input  logic signed [lskt_pkg::KEY_W-1:0]  key,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic [lskt_pkg::POS_W-1:0]         position,
    output logic [lskt_pkg::CMP_W-1:0]         comparisons,
    output logic [lskt_pkg::CMP_W-1:0]         entry_total
);

    import lskt_pkg::*;

    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_data;
    logic [IDX_W-1:0]   rd_addr;
    logic [KEY_W-1:0]   rd_data;

    logic               out_valid_reg, out_valid_next;
    res_t               out_res_reg,   out_res_next;

    lskt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .key       (KEY_W'(key)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    lskt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KEY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_res_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign position    = out_res_reg.position;
    assign comparisons = out_res_reg.comparisons;
    assign entry_total = out_res_reg.entry_total;

    `LSKT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted while busy")
    `LSKT_ASSERT_IMPL(a_full_total, out_valid && status == ST_FULL,
        entry_total == CMP_W'(CAPACITY) && position == '0, "full status with room left")
    `LSKT_ASSERT_IMPL(a_absent_pos, out_valid && status == ST_ABSENT, position == '0,
        "absent key with nonzero position")
    `LSKT_ASSERT_IMPL(a_cmp_bound, out_valid,
        {1'b0, comparisons} <= {1'b0, entry_total} + 1'b1, "too many comparisons")

endmodule

`default_nettype wire
